@@ rtl/fca_pkg.sv @@
// fca_pkg: constants, codes and control types shared by the allocator modules.
// Depends on nothing.
`default_nettype none
package fca_pkg;

  localparam int ENTRIES = 4096;
  localparam int WORD_W = 64;
  localparam int BIT_W = $clog2(WORD_W);
  localparam int WORDS = ENTRIES / WORD_W;
  localparam int WADR_W = $clog2(WORDS);
  localparam int IDX_W = 12;
  localparam int LINK_W = 13;
  localparam logic [LINK_W-1:0] END_OF_CHAIN = {LINK_W{1'b1}};

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_EXPAND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_LINK  = 2'd0,
    RES_ZERO  = 2'd1,
    RES_FRESH = 2'd2,
    RES_FULL  = 2'd3
  } res_sel_t;

  typedef enum logic [1:0] {
    LSRC_INPUT = 2'd0,
    LSRC_END   = 2'd1,
    LSRC_FRESH = 2'd2
  } link_src_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      tgt_fresh;
    logic      tgt_tail;
    logic      wr_link;
    link_src_t link_src;
    logic      mod_used;
    logic      used_val;
    logic      emit;
    res_sel_t  res_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_ok;
    logic tail_ok;
    logic hit;
    logic full;
  } stat_t;

  // index of the lowest set bit; zero when none is set
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fca_ctrl.sv @@
// fca_ctrl: operation sequencer for the allocator.
// Depends on fca_pkg; drives fca_datapath through cmd_t, reads stat_t.
`default_nettype none
module fca_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire fca_pkg::op_t   operation,
  input  wire fca_pkg::stat_t stat,
  output fca_pkg::cmd_t       cmd,
  output logic                busy
);

  typedef enum logic [5:0] {
    S_IDLE        = 6'b000001,
    S_SCAN        = 6'b000010,
    S_LOOK        = 6'b000100,
    S_UPDATE      = 6'b001000,
    S_LOOK_TAIL   = 6'b010000,
    S_UPDATE_TAIL = 6'b100000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.link_src = fca_pkg::LSRC_INPUT;
    cmd.res_sel = fca_pkg::RES_ZERO;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = (operation == fca_pkg::OP_EXPAND) ? S_SCAN : S_LOOK;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.tgt_fresh = 1'b1;
          state_next = S_LOOK;
        end else if (stat.full) begin
          cmd.emit = 1'b1;
          cmd.res_sel = fca_pkg::RES_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_LOOK: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = S_IDLE;
        cmd.emit = 1'b1;
        case (stat.op)
          fca_pkg::OP_READ: begin
            cmd.res_sel = fca_pkg::RES_LINK;
          end
          fca_pkg::OP_WRITE: begin
            cmd.res_sel = fca_pkg::RES_ZERO;
            cmd.wr_link = stat.idx_ok;
            cmd.link_src = fca_pkg::LSRC_INPUT;
            cmd.mod_used = stat.idx_ok;
            cmd.used_val = 1'b1;
          end
          fca_pkg::OP_CLEAR: begin
            cmd.res_sel = fca_pkg::RES_LINK;
            cmd.mod_used = stat.idx_ok;
            cmd.used_val = 1'b0;
          end
          fca_pkg::OP_EXPAND: begin
            cmd.wr_link = 1'b1;
            cmd.link_src = fca_pkg::LSRC_END;
            cmd.mod_used = 1'b1;
            cmd.used_val = 1'b1;
            cmd.res_sel = fca_pkg::RES_FRESH;
            if (stat.tail_ok) begin
              cmd.emit = 1'b0;
              cmd.tgt_tail = 1'b1;
              state_next = S_LOOK_TAIL;
            end
          end
          default: begin
            cmd.res_sel = fca_pkg::RES_ZERO;
          end
        endcase
      end
      S_LOOK_TAIL: begin
        state_next = S_UPDATE_TAIL;
      end
      S_UPDATE_TAIL: begin
        cmd.wr_link = 1'b1;
        cmd.link_src = fca_pkg::LSRC_FRESH;
        cmd.mod_used = 1'b1;
        cmd.used_val = 1'b1;
        cmd.emit = 1'b1;
        cmd.res_sel = fca_pkg::RES_FRESH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/fca_datapath.sv @@
// fca_datapath: link table, used map with row valid bits, free-entry scan, result regs.
// Depends on fca_pkg; controlled by fca_ctrl.
`default_nettype none
module fca_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire fca_pkg::cmd_t               cmd,
  input  wire logic [1:0]                  operation,
  input  wire logic [fca_pkg::IDX_W-1:0]   entry_index,
  input  wire logic signed [fca_pkg::LINK_W-1:0] link_value,
  input  wire logic signed [fca_pkg::LINK_W-1:0] chain_tail,
  output fca_pkg::stat_t                   stat,
  output logic signed [fca_pkg::LINK_W-1:0] result_value,
  output logic                             status,
  output logic                             done
);

  logic [fca_pkg::LINK_W-1:0] link_mem [fca_pkg::ENTRIES];
  logic [fca_pkg::WORD_W-1:0] used_mem [fca_pkg::WORDS];
  logic [fca_pkg::WORDS-1:0]  row_valid;

  fca_pkg::op_t                op_q;
  logic [fca_pkg::IDX_W-1:0]   tgt;
  logic [fca_pkg::LINK_W-1:0]  link_q;
  logic [fca_pkg::LINK_W-1:0]  tail_q;
  logic [fca_pkg::IDX_W-1:0]   fresh_q;
  logic [fca_pkg::WADR_W-1:0]  scan_ptr;
  logic [fca_pkg::WADR_W-1:0]  sa;
  logic                        sv;
  logic [fca_pkg::LINK_W-1:0]  ldata;
  logic [fca_pkg::WORD_W-1:0]  udata;
  logic                        uvalid_q;

  logic [fca_pkg::WADR_W-1:0]  uaddr;
  logic [fca_pkg::WADR_W-1:0]  twaddr;
  logic [fca_pkg::BIT_W-1:0]   tbit;
  logic [fca_pkg::WORD_W-1:0]  eff;
  logic [fca_pkg::WORD_W-1:0]  onehot;
  logic [fca_pkg::WORD_W-1:0]  word_mod;
  logic [fca_pkg::WORD_W-1:0]  free;
  logic [fca_pkg::IDX_W-1:0]   fresh_calc;
  logic [fca_pkg::LINK_W-1:0]  link_wdata;
  logic                        used_bit;
  logic                        idx_ok;
  logic                        tail_ok;
  logic                        hit;

  assign twaddr = tgt[fca_pkg::IDX_W-1:fca_pkg::BIT_W];
  assign tbit = tgt[fca_pkg::BIT_W-1:0];
  assign uaddr = cmd.scan ? scan_ptr : twaddr;
  assign eff = uvalid_q ? udata : '0;
  assign onehot = fca_pkg::WORD_W'(1) << tbit;
  assign word_mod = cmd.used_val ? (eff | onehot) : (eff & ~onehot);
  assign used_bit = eff[tbit];
  assign free = ~eff;
  assign hit = sv && (|free);
  assign fresh_calc = {sa, fca_pkg::lowest_one(free)};
  assign idx_ok = (32'(tgt) < 32'(fca_pkg::ENTRIES));
  assign tail_ok = !tail_q[fca_pkg::LINK_W-1] &&
                   (32'(tail_q[fca_pkg::IDX_W-1:0]) < 32'(fca_pkg::ENTRIES));

  assign stat.op = op_q;
  assign stat.idx_ok = idx_ok;
  assign stat.tail_ok = tail_ok;
  assign stat.hit = hit;
  assign stat.full = sv && !hit && (sa == fca_pkg::WADR_W'(fca_pkg::WORDS - 1));

  always_comb begin
    case (cmd.link_src)
      fca_pkg::LSRC_INPUT: link_wdata = link_q;
      fca_pkg::LSRC_END:   link_wdata = fca_pkg::END_OF_CHAIN;
      fca_pkg::LSRC_FRESH: link_wdata = {1'b0, fresh_q};
      default:             link_wdata = link_q;
    endcase
  end

  // memories: registered reads, single write port each
  always_ff @(posedge clk) begin
    ldata <= link_mem[tgt];
    udata <= used_mem[uaddr];
    if (cmd.wr_link) begin
      link_mem[tgt] <= link_wdata;
    end
    if (cmd.mod_used) begin
      used_mem[twaddr] <= word_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      uvalid_q <= 1'b0;
      sv <= 1'b0;
      done <= 1'b0;
    end else begin
      uvalid_q <= row_valid[uaddr];
      if (cmd.mod_used) begin
        row_valid[twaddr] <= 1'b1;
      end
      sv <= cmd.scan;
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= fca_pkg::op_t'(operation);
      tgt <= entry_index;
      link_q <= link_value;
      tail_q <= chain_tail;
      scan_ptr <= '0;
    end else begin
      if (cmd.scan) begin
        scan_ptr <= scan_ptr + 1'b1;
        sa <= scan_ptr;
      end
      if (cmd.tgt_fresh) begin
        tgt <= fresh_calc;
        fresh_q <= fresh_calc;
      end else if (cmd.tgt_tail) begin
        tgt <= tail_q[fca_pkg::IDX_W-1:0];
      end
    end
    if (cmd.emit) begin
      case (cmd.res_sel)
        fca_pkg::RES_LINK: begin
          result_value <= (idx_ok && used_bit) ? ldata : '0;
          status <= 1'b0;
        end
        fca_pkg::RES_ZERO: begin
          result_value <= '0;
          status <= 1'b0;
        end
        fca_pkg::RES_FRESH: begin
          result_value <= {1'b0, fresh_q};
          status <= 1'b0;
        end
        fca_pkg::RES_FULL: begin
          result_value <= fca_pkg::END_OF_CHAIN;
          status <= 1'b1;
        end
        default: begin
          result_value <= '0;
          status <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/fat_chain_allocator.sv @@
// fat_chain_allocator: top level of the chain allocator, controller plus datapath.
// Depends on fca_pkg, fca_ctrl and fca_datapath.
//
//   channel  handshake             fields
//   request  start & !busy         operation, entry_index, link_value, chain_tail
//   result   done (one cycle)      result_value, status
//
// Read, write and clear go from accept through a memory-read and an update state to
// done. Expand scans the used map one 64-entry word per cycle for the lowest free
// entry, then links a valid tail to it; a full table ends with status set.
// Reset clears the used-map row valid bits at once; no clearing pass is needed.
// busy stays high until the cycle done is shown; results cannot be stalled.
`default_nettype none
module fat_chain_allocator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         operation,
  input  wire logic [fca_pkg::IDX_W-1:0]          entry_index,
  input  wire logic signed [fca_pkg::LINK_W-1:0]  link_value,
  input  wire logic signed [fca_pkg::LINK_W-1:0]  chain_tail,
  output logic                                    done,
  output logic signed [fca_pkg::LINK_W-1:0]       result_value,
  output logic                                    status
);

  fca_pkg::cmd_t  cmd;
  fca_pkg::stat_t stat;
  logic           accept;

  assign accept = start && !busy;

  fca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .operation (fca_pkg::op_t'(operation)),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  fca_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (operation),
    .entry_index  (entry_index),
    .link_value   (link_value),
    .chain_tail   (chain_tail),
    .stat         (stat),
    .result_value (result_value),
    .status       (status),
    .done         (done)
  );

endmodule
`default_nettype wire
